// File: rtl/core/tlb_fifo_page_translate_top_assert.svh
// Assertion macros for the TLB address-translation block.
// Included by the top level; relies on no other file.
`ifndef TLB_FIFO_PAGE_TRANSLATE_TOP_ASSERT_SVH
`define TLB_FIFO_PAGE_TRANSLATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TLBPT_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TLBPT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tlbpt_pkg.sv
// Shared types and constants for the TLB address-translation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

  localparam int PAGE_W   = 8;
  localparam int OFFSET_W = 8;
  localparam int FRAME_W  = 8;
  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int FFREE_W  = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  tag;
    logic [FRAME_W-1:0] frame;
  } tlbpt_entry_t;

  typedef struct packed {
    logic               resident;
    logic [FRAME_W-1:0] frame;
  } tlbpt_pte_t;

endpackage

`default_nettype wire

// File: rtl/core/tlbpt_cell.sv
// One TLB entry cell: holds a mapping, compares it against the looked-up page,
// and takes its neighbor's entry on insert. Depends on tlbpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  tlbpt_pkg::tlbpt_entry_t       prev,
  input  logic [tlbpt_pkg::PAGE_W-1:0]  page,
  output tlbpt_pkg::tlbpt_entry_t       entry,
  output logic                          match,
  output logic [tlbpt_pkg::FRAME_W-1:0] frame_sel
);
  import tlbpt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= prev.valid;
    end
    if (shift) begin
      entry.tag   <= prev.tag;
      entry.frame <= prev.frame;
    end
  end

  assign match     = entry.valid && (entry.tag == page);
  assign frame_sel = match ? entry.frame : '0;

endmodule

`default_nettype wire

// File: rtl/core/tlbpt_ptab.sv
// Page table memory: one write port, one registered read port.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_ptab #(
  parameter int PAGE_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(PAGE_COUNT)-1:0]  wr_idx,
  input  tlbpt_pkg::tlbpt_pte_t          wr_data,
  input  logic [$clog2(PAGE_COUNT)-1:0]  rd_idx,
  output tlbpt_pkg::tlbpt_pte_t          rd_data
);
  import tlbpt_pkg::*;

  tlbpt_pte_t mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

`default_nettype wire

// File: rtl/core/tlb_fifo_page_translate_top.sv
// Top level of the TLB address-translation block: TLB cell chain, page table,
// control sequencer. Depends on tlbpt_pkg, tlbpt_cell, tlbpt_ptab.
`timescale 1ns / 1ps
`default_nettype none

// Translates a 16-bit logical address (page in 15:8, offset in 7:0) through a
// FIFO-replaced TLB built as a chain of entry cells, backed by a demand-paged
// page table in on-chip memory. After reset the page table is cleared one
// entry per cycle with in_stall high. One item is in work at a time: a TLB
// hit is accepted, then resolved by the parallel tag compare; a miss adds a
// step for the page-table memory read (resident update and TLB insert happen
// as the result is registered). The result sits in an output register; the
// next item is accepted while it waits to be taken, but that item holds at
// its result step until the register frees.
module tlb_fifo_page_translate_top #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_addr,
  output logic [tlbpt_pkg::FRAME_W-1:0] frame_number,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0] hit_count,
  output logic [tlbpt_pkg::COUNT_W-1:0] fault_count
);
  import tlbpt_pkg::*;

  `include "tlb_fifo_page_translate_top_assert.svh"

  localparam int PIDX_W = $clog2(PAGE_COUNT);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_WALK} state_t;

  state_t               state;
  logic [PAGE_W-1:0]    lad_page;
  logic [OFFSET_W-1:0]  lad_offset;
  logic [FFREE_W-1:0]   nff;
  logic [COUNT_W-1:0]   hits_total;
  logic [COUNT_W-1:0]   faults_total;
  logic [PIDX_W-1:0]    clr_idx;

  logic [PAGE_W-1:0]    rem;
  logic [PIDX_W-1:0]    pidx;
  logic                 out_free;
  logic                 shift;
  logic                 hit;
  logic [FRAME_W-1:0]   hit_frame;
  logic [FRAME_W-1:0]   walk_frame;
  logic [COUNT_W-1:0]   hits_next;
  logic [COUNT_W-1:0]   faults_next;
  logic                 wr_en;
  logic [PIDX_W-1:0]    wr_idx;
  tlbpt_pte_t           wr_data;
  tlbpt_pte_t           pte;
  tlbpt_entry_t         new_entry;
  tlbpt_entry_t         ent [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match;
  logic [FRAME_W-1:0]   fsel [TLB_ENTRIES];

  // page modulo PAGE_COUNT; quotient is below 16 since PAGE_COUNT >= 16
  always_comb begin
    rem = lad_page;
    for (int k = 3; k >= 0; k--) begin
      if (int'(rem) >= (PAGE_COUNT << k)) begin
        rem = PAGE_W'(int'(rem) - (PAGE_COUNT << k));
      end
    end
    pidx = PIDX_W'(rem);
  end

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);
  assign shift      = (state == S_WALK) && out_free;
  assign walk_frame = pte.resident ? pte.frame : nff[FRAME_W-1:0];
  assign new_entry  = '{valid: 1'b1, tag: lad_page, frame: walk_frame};
  assign hits_next   = (hits_total == COUNT_MAX) ? hits_total : hits_total + COUNT_W'(1);
  assign faults_next = (faults_total == COUNT_MAX) ? faults_total
                                                   : faults_total + COUNT_W'(1);

  generate
    for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
        tlbpt_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .prev      (new_entry),
          .page      (lad_page),
          .entry     (ent[i]),
          .match     (match[i]),
          .frame_sel (fsel[i])
        );
      end else begin : g_body
        tlbpt_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .prev      (ent[i-1]),
          .page      (lad_page),
          .entry     (ent[i]),
          .match     (match[i]),
          .frame_sel (fsel[i])
        );
      end
    end
  endgenerate

  // tags are unique, so OR-ing masked frames selects the hit
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit       = hit | match[i];
      hit_frame = hit_frame | fsel[i];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pidx;
    wr_data = '{resident: 1'b1, frame: nff[FRAME_W-1:0]};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx;
      wr_data = '0;
    end else if (shift && !pte.resident) begin
      wr_en = 1'b1;
    end
  end

  tlbpt_ptab #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ptab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (pidx),
    .rd_data (pte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      nff          <= '0;
      hits_total   <= '0;
      faults_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == PIDX_W'(PAGE_COUNT - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + PIDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            lad_page   <= logical_addr[ADDR_W-1:OFFSET_W];
            lad_offset <= logical_addr[OFFSET_W-1:0];
            state      <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!hit) begin
            state <= S_WALK;
          end else if (out_free) begin
            hits_total    <= hits_next;
            physical_addr <= {hit_frame, lad_offset};
            frame_number  <= hit_frame;
            tlb_hit       <= 1'b1;
            page_fault    <= 1'b0;
            hit_count     <= hits_next;
            fault_count   <= faults_total;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_WALK: begin
          if (out_free) begin
            physical_addr <= {walk_frame, lad_offset};
            frame_number  <= walk_frame;
            tlb_hit       <= 1'b0;
            page_fault    <= !pte.resident;
            hit_count     <= hits_total;
            fault_count   <= pte.resident ? faults_total : faults_next;
            if (!pte.resident) begin
              nff          <= nff + FFREE_W'(1);
              faults_total <= faults_next;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TLBPT_ASSERT_IMPL(a_tlb_unique, clk, rst, state == S_LOOK, $onehot0(match),
    "more than one TLB entry matches the page")
  `TLBPT_ASSERT_IMPL(a_hit_no_fault, clk, rst, out_valid, !(tlb_hit && page_fault),
    "item flagged as both TLB hit and page fault")
  `TLBPT_ASSERT_IMPL(a_paddr_frame, clk, rst, out_valid,
    physical_addr[ADDR_W-1:OFFSET_W] == frame_number,
    "physical address disagrees with frame number")
  `TLBPT_ASSERT_NEXT(a_frame_advance, clk, rst, shift && !pte.resident,
    nff == $past(nff) + FFREE_W'(1),
    "free frame pointer did not advance on a fault")

endmodule

`default_nettype wire
